[rtl/modexp_prime_modulus_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Shared forms for same-cycle and next-cycle implications on the clock.
// ---------------------------------------------------------------------------
`ifndef MODEXP_PRIME_MODULUS_CORE_DEFINES_SVH
`define MODEXP_PRIME_MODULUS_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mpm_pkg.sv]
// ---------------------------------------------------------------------------
// mpm_pkg
// Constants and request/response types for the modular exponentiation core.
// ---------------------------------------------------------------------------
package mpm_pkg;

  localparam int RES_W = 30;

  // Prime modulus and Barrett constants
  localparam logic [63:0] PRIME64    = 64'd1000000007;
  localparam logic [31:0] PRIME      = PRIME64[31:0];
  localparam logic [63:0] TWO_POW_60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] TWO_POW_32 = 64'h0000_0001_0000_0000;
  localparam logic [31:0] BARRETT_MU = 32'(TWO_POW_60 / PRIME64);
  // 2^32 mod prime, used to fold the upper half of the base
  localparam logic [31:0] FOLD_32    = 32'(TWO_POW_32 % PRIME64);

  typedef struct packed {
    logic        start;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } mulred_req_t;

  typedef struct packed {
    logic             done;
    logic [RES_W-1:0] r;
  } mulred_rsp_t;

endpackage

[rtl/mpm_mulred.sv]
// ---------------------------------------------------------------------------
// mpm_mulred
// Multi-cycle (x*y + z) mod prime, Barrett reduction on one shared multiplier.
// ---------------------------------------------------------------------------
module mpm_mulred
  import mpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  mulred_req_t req,
  output mulred_rsp_t rsp
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MUL  = 3'd1;
  localparam logic [2:0] U_QEST = 3'd2;
  localparam logic [2:0] U_QP   = 3'd3;
  localparam logic [2:0] U_SUB  = 3'd4;
  localparam logic [2:0] U_FIX  = 3'd5;

  logic [2:0]       state;
  logic [31:0]      x;
  logic [31:0]      y;
  logic [31:0]      z;
  logic [63:0]      t;
  logic [63:0]      p;
  logic [31:0]      r;
  logic [RES_W-1:0] res;
  logic             done;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [31:0] r1;
  logic [31:0] r2;

  // Select multiplier operands for the current step
  always_comb begin
    unique case (state)
      U_QEST: begin
        mul_a = t[60:29];
        mul_b = BARRETT_MU;
      end
      U_QP: begin
        mul_a = p[62:31];
        mul_b = PRIME;
      end
      default: begin
        mul_a = x;
        mul_b = y;
      end
    endcase
  end

  assign prod = {32'd0, mul_a} * {32'd0, mul_b};

  // Drop the remainder below the prime, at most two subtractions
  assign r1 = (r >= PRIME) ? (r - PRIME) : r;
  assign r2 = (r1 >= PRIME) ? (r1 - PRIME) : r1;

  // Step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: if (req.start) begin
          state <= U_MUL;
        end
        U_MUL:   state <= U_QEST;
        U_QEST:  state <= U_QP;
        U_QP:    state <= U_SUB;
        U_SUB:   state <= U_FIX;
        U_FIX: begin
          state <= U_IDLE;
          done  <= 1'b1;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: if (req.start) begin
        x <= req.x;
        y <= req.y;
        z <= req.z;
      end
      U_MUL:  t   <= prod + {32'd0, z};
      U_QEST: p   <= prod;
      U_QP:   p   <= prod;
      // True difference stays below three times the prime
      U_SUB:  r   <= t[31:0] - p[31:0];
      U_FIX:  res <= r2[RES_W-1:0];
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.r    = res;

endmodule

[rtl/modexp_prime_modulus_core.sv]
// ---------------------------------------------------------------------------
// modexp_prime_modulus_core
// Raises a 64-bit base to a 64-bit exponent modulo the prime 1000000007.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one word of base and exponent.
//   Output channel out_valid/out_ready carries one word of power_mod.
//   One item is in flight at a time: in_ready is high only while idle.
//   The base is folded mod the prime in two passes, then the exponent is
//   scanned from its least significant bit by square-and-multiply.
//   Every modular product goes through one shared Barrett unit built on a
//   single 32x32 multiplier. A new word is taken the cycle after the result
//   is accepted. When the receiver stalls, the result holds in the output
//   register and the block stays busy. Synchronous reset returns it to idle
//   with no result pending.
// ---------------------------------------------------------------------------
module modexp_prime_modulus_core
  import mpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [63:0]      base,
  input  logic [63:0]      exponent,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RES_W-1:0] power_mod
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RED_HI = 3'd1;
  localparam logic [2:0] S_RED_LO = 3'd2;
  localparam logic [2:0] S_STEP   = 3'd3;
  localparam logic [2:0] S_MACC   = 3'd4;
  localparam logic [2:0] S_SQR    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [63:0]      e;
  logic [31:0]      b_lo;
  logic [RES_W-1:0] acc;
  logic [RES_W-1:0] sq;

  mulred_req_t req;
  mulred_rsp_t rsp;

  mpm_mulred u_mulred (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Sequence products and issue requests to the shared unit
  always_comb begin
    state_next = state;
    req        = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        req.start  = 1'b1;
        req.x      = base[63:32];
        req.y      = 32'd1;
        state_next = S_RED_HI;
      end
      S_RED_HI: if (rsp.done) begin
        req.start  = 1'b1;
        req.x      = {2'd0, rsp.r};
        req.y      = FOLD_32;
        req.z      = b_lo;
        state_next = S_RED_LO;
      end
      S_RED_LO: if (rsp.done) begin
        state_next = S_STEP;
      end
      S_STEP: begin
        if (e == 64'd0) begin
          state_next = S_OUT;
        end else if (e[0]) begin
          req.start  = 1'b1;
          req.x      = {2'd0, acc};
          req.y      = {2'd0, sq};
          state_next = S_MACC;
        end else begin
          req.start  = 1'b1;
          req.x      = {2'd0, sq};
          req.y      = {2'd0, sq};
          state_next = S_SQR;
        end
      end
      S_MACC: if (rsp.done) begin
        req.start  = 1'b1;
        req.x      = {2'd0, sq};
        req.y      = {2'd0, sq};
        state_next = S_SQR;
      end
      S_SQR: if (rsp.done) begin
        state_next = S_STEP;
      end
      S_OUT: if (out_ready) begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold operands, accumulator and running square
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        e    <= exponent;
        b_lo <= base[31:0];
        acc  <= RES_W'(1);
      end
      S_RED_LO: if (rsp.done) begin
        sq <= rsp.r;
      end
      S_MACC: if (rsp.done) begin
        acc <= rsp.r;
      end
      S_SQR: if (rsp.done) begin
        sq <= rsp.r;
        e  <= {1'b0, e[63:1]};
      end
      default: ;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign power_mod = acc;

endmodule

[rtl/mpm_checker.sv]
// ---------------------------------------------------------------------------
// mpm_checker
// Port-level checks on the modular exponentiation core, bound to the top.
// ---------------------------------------------------------------------------
`include "modexp_prime_modulus_core_defines.svh"

module mpm_checker
  import mpm_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [63:0]      base,
  input logic [63:0]      exponent,
  input logic             out_valid,
  input logic             out_ready,
  input logic [RES_W-1:0] power_mod
);

  logic in_word;
  logic in_seen;

  // Track accepted input words, whatever their payload
  assign in_word = in_valid && in_ready && (base != 64'd0 || exponent != 64'd0 || 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_seen <= 1'b0;
    end else if (in_word) begin
      in_seen <= 1'b1;
    end
  end

  // Stalled result word holds
  `MPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(power_mod), "result word changed while stalled")
  // Busy straight after taking a word
  `MPM_ASSERT_NEXT(a_busy_after_in, in_word, !in_ready && !out_valid, "not busy after input word")
  // No new word while a result is pending
  `MPM_ASSERT_SAME(a_one_in_flight, out_valid, !in_ready, "input taken while result pending")
  // Result lies below the prime, and only after some word was taken
  `MPM_ASSERT_SAME(a_out_range, out_valid, in_seen && (power_mod < 30'd1000000007), "result out of range")

endmodule

bind modexp_prime_modulus_core mpm_checker u_mpm_checker (.*);

[tb/tb_modexp_prime_modulus_core.sv]
// ---------------------------------------------------------------------------
// tb_modexp_prime_modulus_core
// Self-checking bench for the mod-1000000007 exponentiation core. A ledger
// class works out base^exponent by its own square-and-multiply for every
// accepted input word, and matches each output word against the oldest
// expected power. Stimulus runs as a directed set of edge values, then
// random words through several idling phases, one long output hold-off and
// a drain pause between phases.
// ---------------------------------------------------------------------------
module tb_modexp_prime_modulus_core;
  import mpm_pkg::*;

  localparam logic [63:0] MODULUS         = 64'd1000000007;
  localparam int          STALL_LIMIT     = 20000;
  localparam int          HOLD_OFF_CYCLES = 1500;
  localparam int          SETTLE_CYCLES   = 1000;
  localparam int          PHASE_WORDS     = 195;

  // Expected powers, in order of acceptance
  class modexp_ledger;
    logic [RES_W-1:0] expected_powers[$];
    int               mismatches;
    int               words_in;
    int               words_out;

    function new();
      mismatches = 0;
      words_in   = 0;
      words_out  = 0;
    endfunction

    // Scan the exponent from its least significant bit
    function logic [RES_W-1:0] mod_power(logic [63:0] b, logic [63:0] e);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] rest;
      acc  = 64'd1;
      sq   = b % MODULUS;
      rest = e;
      while (rest != 64'd0) begin
        if (rest[0]) begin
          acc = (acc * sq) % MODULUS;
        end
        rest = rest >> 1;
        sq   = (sq * sq) % MODULUS;
      end
      return acc[RES_W-1:0];
    endfunction

    function void note_word(logic [63:0] b, logic [63:0] e);
      expected_powers.insert(expected_powers.size(), mod_power(b, e));
      words_in++;
    endfunction

    task flag_mismatch(string msg);
      $display("[tb] ERROR: %s", msg);
      mismatches++;
    endtask

    task check_word(logic [RES_W-1:0] got);
      logic [RES_W-1:0] want;
      words_out++;
      if (expected_powers.size() == 0) begin
        flag_mismatch($sformatf("power_mod %0d with no word outstanding", got));
      end else begin
        want = expected_powers.pop_front();
        if (got !== want) begin
          flag_mismatch($sformatf("result %0d: power_mod %0d, expected %0d",
                                  words_out, got, want));
        end
      end
    endtask

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [63:0]      base      = 64'd0;
  logic [63:0]      exponent  = 64'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [RES_W-1:0] power_mod;

  modexp_ledger ledger = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;

  modexp_prime_modulus_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base      (base),
    .exponent  (exponent),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .power_mod (power_mod)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one word; drop valid only when an idle gap is taken first
  task send_word(input logic [63:0] b_word, input logic [63:0] e_word);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    base     <= b_word;
    exponent <= e_word;
    do @(posedge clk); while (!in_ready);
    ledger.note_word(b_word, e_word);
  endtask

  // Hold the input idle until every outstanding result is back
  task pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  // Draw a random word, weighted towards short exponents and modulus multiples
  task make_word(output logic [63:0] b_word, output logic [63:0] e_word);
    int          pick;
    int          width;
    logic [63:0] mask;
    pick   = $urandom_range(99);
    width  = $urandom_range(64);
    mask   = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    b_word = {$urandom, $urandom};
    e_word = {$urandom, $urandom};
    if (pick < 40) begin
      // full-width exponent, left as drawn
    end else if (pick < 70) begin
      e_word = e_word & mask;
    end else if (pick < 80) begin
      e_word = 64'($urandom_range(3));
    end else if (pick < 90) begin
      b_word = MODULUS * 64'($urandom);
      e_word = e_word & mask;
    end else begin
      b_word = MODULUS * 64'($urandom_range(3)) + 64'($urandom_range(2)) - 64'd1;
    end
  endtask

  // Drive out_ready: random stalls, or a long counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        ledger.check_word(power_mod);
      end
    end
  end

  // End the run if no word moves on either side for too long
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[tb] no handshake for %0d cycles, %0d results outstanding",
             STALL_LIMIT, ledger.pending());
    $display("modexp_prime_modulus_core: mismatch");
    $finish;
  end

  initial begin
    logic [63:0] b_word;
    logic [63:0] e_word;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Edge values: zero exponent, modulus multiples, all-ones fields
    send_word(64'd0, 64'd0);
    send_word(MODULUS, 64'd0);
    send_word(MODULUS, 64'd5);
    send_word(MODULUS * 64'd2, '1);
    send_word(64'd0, 64'd1);
    send_word(64'd0, '1);
    send_word('1, '1);
    send_word('1, 64'd0);
    send_word('1, 64'd1);
    send_word(64'd1, '1);
    send_word(MODULUS - 64'd1, 64'd2);
    send_word(MODULUS - 64'd1, '1);
    send_word(MODULUS + 64'd1, 64'd12345);
    send_word(64'd2, 64'd63);
    send_word(64'd2, 64'd64);
    send_word(64'd2, 64'h8000_0000_0000_0000);
    send_word(64'h8000_0000_0000_0000, 64'd3);
    send_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(64'h0000_0001_0000_0000, MODULUS - 64'd1);
    pause_until_drained();

    // Phase loop: none, sender idle, receiver stalling, both lightly
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 9;
          recv_stall_pct = 9;
        end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        make_word(b_word, e_word);
        send_word(b_word, e_word);
      end
      pause_until_drained();
    end

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("[tb] %0d words sent, %0d results checked", ledger.words_in,
             ledger.words_out);
    $display("[tb] covered edge values, four idling mixes and a %0d-cycle hold-off",
             HOLD_OFF_CYCLES);
    if (ledger.mismatches == 0) begin
      $display("modexp_prime_modulus_core: match");
    end else begin
      $display("modexp_prime_modulus_core: mismatch");
    end
    $finish;
  end

endmodule
